### rtl/pls_pkg.sv
// Shared types, constants and address helper for the positional list store.
`default_nettype none

package pls_pkg;

    localparam int CAPACITY = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int PW       = ((CW > 8) ? CW : 8) + 1;
    localparam int DW       = 32;
    localparam int CNT_W    = 6;
    localparam int OQ_DEPTH = 3;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_READ_ALL  = 3'd6,
        CMD_COUNT     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_RESP,
        S_RDOUT,
        S_RDWAIT
    } state_t;

    typedef struct packed {
        logic signed [DW-1:0] read_value;
        logic [CNT_W-1:0]     entry_count;
        status_t              status;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic          we;
        addr_t         waddr;
        logic [DW-1:0] wdata;
        addr_t         raddr;
    } ram_req_t;

    // Logical slot -> physical address in the circular buffer.
    function automatic addr_t phys(addr_t head, cnt_t idx);
        logic [AW+1:0] sum;
        sum = (AW+2)'(head) + (AW+2)'(idx);
        if (sum >= (AW+2)'(CAPACITY))
        begin
            sum = sum - (AW+2)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/pls_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/pls_outq.sv
// Small result queue that decouples the sequencer from the output handshake.
`default_nettype none

module pls_outq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire pls_pkg::result_t             push_data,
    output logic      [pls_pkg::OQ_CW-1:0]    free_slots,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output pls_pkg::result_t                  out_data
);

    pls_pkg::result_t              q_reg [pls_pkg::OQ_DEPTH];
    logic [pls_pkg::OQ_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pls_pkg::OQ_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pls_pkg::OQ_CW-1:0]     occ_reg, occ_next;
    logic                          pop;

    assign out_valid = (occ_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = q_reg[rd_ptr_reg];

    // Free slots counting an entry leaving this cycle.
    assign free_slots = pls_pkg::OQ_CW'(pls_pkg::OQ_DEPTH) - occ_reg
                        + pls_pkg::OQ_CW'(pop);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == pls_pkg::OQ_AW'(pls_pkg::OQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + pls_pkg::OQ_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pls_pkg::OQ_AW'(pls_pkg::OQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + pls_pkg::OQ_AW'(1);
        end
        occ_next = occ_reg + pls_pkg::OQ_CW'(push) - pls_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/pls_ctrl.sv
// Command sequencer: decodes commands and runs shift and read-out sweeps over the RAM.
`default_nettype none

module pls_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [2:0]                     command,
    input  wire logic signed [pls_pkg::DW-1:0]  value,
    input  wire logic [7:0]                     position,
    output pls_pkg::ram_req_t                   ram_req,
    input  wire logic [pls_pkg::DW-1:0]         ram_rdata,
    output logic                                push,
    output pls_pkg::result_t                    push_data,
    input  wire logic [pls_pkg::OQ_CW-1:0]      free_slots
);

    pls_pkg::state_t           state_reg, state_next, acc_state;
    pls_pkg::addr_t            head_reg, head_next, acc_head;
    pls_pkg::cnt_t             count_reg, count_next, acc_count;
    pls_pkg::cnt_t             cursor_reg, cursor_next, acc_cursor;
    pls_pkg::cnt_t             end_reg, end_next, acc_end;
    pls_pkg::cnt_t             idx_reg, idx_next, acc_idx;
    pls_pkg::cnt_t             pend_idx_reg, pend_idx_next;
    logic                      up_reg, up_next, acc_up;
    logic                      pend_reg, pend_next;
    logic                      rd_pend_reg, rd_pend_next;
    logic                      rd_last_reg, rd_last_next;
    logic [pls_pkg::DW-1:0]    value_reg, value_next;
    pls_pkg::status_t          status_reg, status_next, acc_status;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      ins_pos_ok;
    logic                      del_pos_ok;
    logic                      issue;
    logic                      at_last;
    logic [pls_pkg::PW-1:0]    pos_w;
    logic [pls_pkg::PW-1:0]    cnt_w;
    pls_pkg::cnt_t             idx_in;
    pls_pkg::cnt_t             cnt_m1;
    pls_pkg::addr_t            head_dec;
    pls_pkg::addr_t            head_inc;
    pls_pkg::cnt_t             wr_slot;

    assign accept  = in_valid && in_ready;
    assign full    = (count_reg == pls_pkg::cnt_t'(pls_pkg::CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_w   = pls_pkg::PW'(position);
    assign cnt_w   = pls_pkg::PW'(count_reg);
    assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + pls_pkg::PW'(1));
    assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
    assign idx_in  = pls_pkg::cnt_t'(pos_w - pls_pkg::PW'(1));
    assign cnt_m1  = count_reg - pls_pkg::cnt_t'(1);
    assign head_dec = (head_reg == '0) ? pls_pkg::AW'(pls_pkg::CAPACITY - 1)
                                       : head_reg - pls_pkg::AW'(1);
    assign head_inc = (head_reg == pls_pkg::AW'(pls_pkg::CAPACITY - 1))
                      ? '0 : head_reg + pls_pkg::AW'(1);
    assign at_last = (cursor_reg == cnt_m1);

    // Read-out issues a RAM read only when the queue can take the data.
    assign issue = (state_reg == pls_pkg::S_RDOUT)
                   && (free_slots > pls_pkg::OQ_CW'(rd_pend_reg));

    // Command decode at acceptance
    always_comb
    begin
        acc_state  = pls_pkg::S_RESP;
        acc_status = pls_pkg::ST_OK;
        acc_head   = head_reg;
        acc_count  = count_reg;
        acc_idx    = idx_in;
        acc_cursor = '0;
        acc_end    = '0;
        acc_up     = 1'b0;
        unique case (pls_pkg::cmd_t'(command))
            pls_pkg::CMD_INS_FRONT:
            begin
                if (full)
                begin
                    acc_status = pls_pkg::ST_FULL;
                end
                else
                begin
                    acc_head  = head_dec;
                    acc_idx   = '0;
                    acc_state = pls_pkg::S_PUT;
                end
            end
            pls_pkg::CMD_INS_BACK:
            begin
                if (full)
                begin
                    acc_status = pls_pkg::ST_FULL;
                end
                else
                begin
                    acc_idx   = count_reg;
                    acc_state = pls_pkg::S_PUT;
                end
            end
            pls_pkg::CMD_INS_AT:
            begin
                if (full)
                begin
                    acc_status = pls_pkg::ST_FULL;
                end
                else if (!ins_pos_ok)
                begin
                    acc_status = pls_pkg::ST_BADPOS;
                end
                else if (idx_in == '0)
                begin
                    acc_head  = head_dec;
                    acc_idx   = '0;
                    acc_state = pls_pkg::S_PUT;
                end
                else if (idx_in == count_reg)
                begin
                    acc_state = pls_pkg::S_PUT;
                end
                else
                begin
                    acc_state  = pls_pkg::S_SHIFT;
                    acc_up     = 1'b1;
                    acc_cursor = cnt_m1;
                    acc_end    = idx_in;
                end
            end
            pls_pkg::CMD_DEL_FRONT:
            begin
                if (empty)
                begin
                    acc_status = pls_pkg::ST_EMPTY;
                end
                else
                begin
                    acc_head  = head_inc;
                    acc_count = cnt_m1;
                end
            end
            pls_pkg::CMD_DEL_BACK:
            begin
                if (empty)
                begin
                    acc_status = pls_pkg::ST_EMPTY;
                end
                else
                begin
                    acc_count = cnt_m1;
                end
            end
            pls_pkg::CMD_DEL_AT:
            begin
                if (empty)
                begin
                    acc_status = pls_pkg::ST_EMPTY;
                end
                else if (!del_pos_ok)
                begin
                    acc_status = pls_pkg::ST_BADPOS;
                end
                else if (idx_in == cnt_m1)
                begin
                    acc_count = cnt_m1;
                end
                else if (idx_in == '0)
                begin
                    acc_head  = head_inc;
                    acc_count = cnt_m1;
                end
                else
                begin
                    acc_state  = pls_pkg::S_SHIFT;
                    acc_cursor = idx_in + pls_pkg::cnt_t'(1);
                    acc_end    = cnt_m1;
                end
            end
            pls_pkg::CMD_READ_ALL:
            begin
                if (empty)
                begin
                    acc_status = pls_pkg::ST_EMPTY;
                end
                else
                begin
                    acc_state = pls_pkg::S_RDOUT;
                end
            end
            pls_pkg::CMD_COUNT:
            begin
                acc_state = pls_pkg::S_RESP;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = acc_state;
                end
            end
            pls_pkg::S_SHIFT:
            begin
                if (cursor_reg == end_reg)
                begin
                    state_next = pls_pkg::S_DRAIN;
                end
            end
            pls_pkg::S_DRAIN:
            begin
                state_next = up_reg ? pls_pkg::S_PUT : pls_pkg::S_RESP;
            end
            pls_pkg::S_PUT:
            begin
                state_next = pls_pkg::S_RESP;
            end
            pls_pkg::S_RESP:
            begin
                if (free_slots != '0)
                begin
                    state_next = pls_pkg::S_IDLE;
                end
            end
            pls_pkg::S_RDOUT:
            begin
                if (issue && at_last)
                begin
                    state_next = pls_pkg::S_RDWAIT;
                end
            end
            pls_pkg::S_RDWAIT:
            begin
                state_next = pls_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pls_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        up_next       = up_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = 1'b0;
        rd_pend_next  = issue;
        rd_last_next  = at_last;
        unique case (state_reg)
            pls_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    head_next   = acc_head;
                    count_next  = acc_count;
                    cursor_next = acc_cursor;
                    end_next    = acc_end;
                    idx_next    = acc_idx;
                    up_next     = acc_up;
                    value_next  = value;
                    status_next = acc_status;
                end
            end
            pls_pkg::S_SHIFT:
            begin
                // Data read this cycle lands one slot toward the gap.
                pend_next = 1'b1;
                if (up_reg)
                begin
                    pend_idx_next = cursor_reg + pls_pkg::cnt_t'(1);
                    cursor_next   = cursor_reg - pls_pkg::cnt_t'(1);
                end
                else
                begin
                    pend_idx_next = cursor_reg - pls_pkg::cnt_t'(1);
                    cursor_next   = cursor_reg + pls_pkg::cnt_t'(1);
                end
            end
            pls_pkg::S_DRAIN:
            begin
                if (!up_reg)
                begin
                    count_next = cnt_m1;
                end
            end
            pls_pkg::S_PUT:
            begin
                count_next = count_reg + pls_pkg::cnt_t'(1);
            end
            pls_pkg::S_RDOUT:
            begin
                if (issue)
                begin
                    cursor_next = cursor_reg + pls_pkg::cnt_t'(1);
                end
            end
            pls_pkg::S_RESP, pls_pkg::S_RDWAIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Outputs: handshake, RAM port and result push
    always_comb
    begin
        in_ready          = (state_reg == pls_pkg::S_IDLE);
        wr_slot           = pend_idx_reg;
        ram_req.we        = 1'b0;
        ram_req.wdata     = ram_rdata;
        ram_req.raddr     = pls_pkg::phys(head_reg, cursor_reg);
        push              = 1'b0;
        push_data.read_value  = '0;
        push_data.entry_count = pls_pkg::CNT_W'(count_reg);
        push_data.status      = status_reg;
        push_data.last        = 1'b1;
        unique case (state_reg)
            pls_pkg::S_SHIFT:
            begin
                ram_req.we = pend_reg;
            end
            pls_pkg::S_DRAIN:
            begin
                ram_req.we = 1'b1;
            end
            pls_pkg::S_PUT:
            begin
                ram_req.we    = 1'b1;
                wr_slot       = idx_reg;
                ram_req.wdata = value_reg;
            end
            pls_pkg::S_RESP:
            begin
                push = (free_slots != '0);
            end
            pls_pkg::S_IDLE, pls_pkg::S_RDOUT, pls_pkg::S_RDWAIT:
            begin
            end
            default:
            begin
            end
        endcase
        if (rd_pend_reg)
        begin
            push                 = 1'b1;
            push_data.read_value = ram_rdata;
            push_data.status     = pls_pkg::ST_OK;
            push_data.last       = rd_last_reg;
        end
        ram_req.waddr = pls_pkg::phys(head_reg, wr_slot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pls_pkg::S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cursor_reg   <= cursor_next;
        end_reg      <= end_next;
        idx_reg      <= idx_next;
        up_reg       <= up_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        pend_idx_reg <= pend_idx_next;
        rd_last_reg  <= rd_last_next;
    end

endmodule

`default_nettype wire

### rtl/positional_list_store_core.sv
// Top level of the positional list store: sequencer, entry RAM and result queue.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_ready   | command, value, position
//  out     | out_valid / out_ready | read_value, entry_count, status, last
//
// Entries live in one RAM used as a circular buffer (head pointer + count),
// so front/back inserts and deletes need no data movement. Single-result
// commands go straight to the response state; inserts without a shift pass
// through the write state first. A middle insert or delete runs a shift
// sweep, one RAM read/write pair per moved entry, then a drain step (and a
// write step for an insert). A read-out streams one transaction per cycle while out_ready is high.
// Reset clears the control state only; RAM contents stay undefined and no
// entry is read before it is written. A stalled output fills the 3-deep
// result queue, after which read-out sweeps and the final result push of a
// command wait, so the next command is held off; shift sweeps run on.
`default_nettype none

module positional_list_store_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    command,
    input  wire logic signed [pls_pkg::DW-1:0] value,
    input  wire logic [7:0]                    position,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [pls_pkg::DW-1:0]      read_value,
    output logic [pls_pkg::CNT_W-1:0]          entry_count,
    output logic [1:0]                         status,
    output logic                               last
);

    pls_pkg::ram_req_t             ram_req;
    logic [pls_pkg::DW-1:0]        ram_rdata;
    logic                          push;
    pls_pkg::result_t              push_data;
    pls_pkg::result_t              out_data;
    logic [pls_pkg::OQ_CW-1:0]     free_slots;

    pls_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .position   (position),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .push       (push),
        .push_data  (push_data),
        .free_slots (free_slots)
    );

    // Entry storage: one write, one registered read per cycle.
    pls_ram #(
        .WIDTH (pls_pkg::DW),
        .DEPTH (pls_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Result queue parts the output handshake from the sequencer.
    pls_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .free_slots (free_slots),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign read_value  = out_data.read_value;
    assign entry_count = out_data.entry_count;
    assign status      = out_data.status;
    assign last        = out_data.last;

endmodule

`default_nettype wire

### test/positional_list_store_core_tb.sv
// Self-checking testbench for the positional list store core.
`timescale 1ns / 1ps

module positional_list_store_core_tb;

    import pls_pkg::*;

    // Watchdog limit in clock cycles. The slowest correct run (every command a
    // full read-out, every transaction held off the longest drawn gap) stays far below it.
    localparam longint CYCLE_LIMIT = 1000000;
    // Settling time after the last reply; covers the longest middle shift.
    localparam int     TAIL_CYCLES = 80;

    // One command as queued for the driver. A hurried command leaves no gap
    // after it is taken, which gives back-to-back stretches.
    typedef struct {
        cmd_t                 op;
        logic signed [DW-1:0] data;
        logic [7:0]           pos;
        bit                   hurry;
    } list_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [2:0]           command = '0;
    logic signed [DW-1:0] value = '0;
    logic [7:0]           position = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [DW-1:0] read_value;
    logic [CNT_W-1:0]     entry_count;
    logic [1:0]           status;
    logic                 last;

    positional_list_store_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .entry_count(entry_count),
        .status     (status),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // List model: packed array, slot 0 is the front.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] model_entries [0:CAPACITY-1];
    int                   model_count = 0;
    result_t              pending_replies [$];

    list_cmd_t            queued_cmds [$];
    int                   gen_count = 0;     // entry count as seen by the generator
    int                   queued_total = 0;

    bit                   cmd_taken = 1'b0;  // transaction on the input at last rising edge
    bit                   res_taken = 1'b0;  // transaction on the output at last rising edge
    int                   replies_seen = 0;
    int                   mismatches = 0;
    int                   send_hold = 0;
    int                   ready_hold = 0;
    bit                   long_hold_done = 1'b0;
    longint               cycle_count = 0;

    function automatic void add_reply(logic signed [DW-1:0] rv, status_t st, logic fin);
        result_t r;
        r.read_value  = rv;
        r.entry_count = CNT_W'(model_count);
        r.status      = st;
        r.last        = fin;
        pending_replies.push_back(r);
    endfunction

    function automatic void store_entry(int slot, logic signed [DW-1:0] v);
        for (int i = model_count; i > slot; i--)
        begin
            model_entries[i] = model_entries[i-1];
        end
        model_entries[slot] = v;
        model_count++;
    endfunction

    function automatic void remove_entry(int slot);
        for (int i = slot; i + 1 < model_count; i++)
        begin
            model_entries[i] = model_entries[i+1];
        end
        model_count--;
    endfunction

    // Applies one accepted command to the model and queues its replies.
    function automatic void update_list_model(cmd_t op, logic signed [DW-1:0] v,
                                              logic [7:0] p);
        status_t st;
        int      pi;
        st = ST_OK;
        pi = p;
        case (op)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT:
            begin
                // fullness is checked before the position
                if (model_count >= CAPACITY)
                    st = ST_FULL;
                else if (op == CMD_INS_FRONT)
                    store_entry(0, v);
                else if (op == CMD_INS_BACK)
                    store_entry(model_count, v);
                else if (pi < 1 || pi > model_count + 1)
                    st = ST_BADPOS;
                else
                    store_entry(pi - 1, v);
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT:
            begin
                // empty wins over a bad position
                if (model_count == 0)
                    st = ST_EMPTY;
                else if (op == CMD_DEL_FRONT)
                    remove_entry(0);
                else if (op == CMD_DEL_BACK)
                    remove_entry(model_count - 1);
                else if (pi < 1 || pi > model_count)
                    st = ST_BADPOS;
                else
                    remove_entry(pi - 1);
            end
            CMD_READ_ALL:
            begin
                if (model_count == 0)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < model_count; i++)
                    begin
                        add_reply(model_entries[i], ST_OK, (i == model_count - 1));
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        add_reply('0, st, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Command generation
    // ------------------------------------------------------------------
    task automatic queue_cmd(cmd_t op, logic signed [DW-1:0] v, int p, bit hurry);
        list_cmd_t c;
        c.op    = op;
        c.data  = v;
        c.pos   = p[7:0];
        c.hurry = hurry;
        queued_cmds.push_back(c);
        queued_total++;
        // track the count so that positions can be aimed at valid slots
        case (op)
            CMD_INS_FRONT, CMD_INS_BACK:
                if (gen_count < CAPACITY)
                    gen_count++;
            CMD_INS_AT:
                if (gen_count < CAPACITY && p >= 1 && p <= gen_count + 1)
                    gen_count++;
            CMD_DEL_FRONT, CMD_DEL_BACK:
                if (gen_count > 0)
                    gen_count--;
            CMD_DEL_AT:
                if (gen_count > 0 && p >= 1 && p <= gen_count)
                    gen_count--;
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a valid slot in 1..top, otherwise zero, past the end, or noise.
    function automatic int pick_position(int top);
        int r;
        r = $urandom_range(0, 99);
        if (r < 82 && top >= 1)
            return $urandom_range(1, top);
        else if (r < 88)
            return 0;
        else if (r < 94)
            return $urandom_range(top + 1, 255);
        else
            return $urandom_range(0, 255);
    endfunction

    // grow_pct: share of list edits that insert.
    task automatic queue_random_cmd(int grow_pct, bit hurry);
        int   r;
        cmd_t op;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            queue_cmd(CMD_READ_ALL, $urandom, $urandom_range(0, 255), hurry);
        end
        else if (r < 10)
        begin
            queue_cmd(CMD_COUNT, $urandom, $urandom_range(0, 255), hurry);
        end
        else if (r < 16)
        begin
            queue_cmd(cmd_t'($urandom_range(0, 7)), $urandom, $urandom_range(0, 255), hurry);
        end
        else if ($urandom_range(0, 99) < grow_pct)
        begin
            op = cmd_t'($urandom_range(0, 2));
            queue_cmd(op, pick_value(), pick_position(gen_count + 1), hurry);
        end
        else
        begin
            op = cmd_t'($urandom_range(3, 5));
            queue_cmd(op, $urandom, pick_position(gen_count), hurry);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. Holds the payload until
    // the transaction is seen, then waits the drawn gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_cmds
        list_cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !cmd_taken)
        begin
            // still offered, payload stays put
        end
        else if (send_hold != 0)
        begin
            in_valid  <= 1'b0;
            send_hold <= send_hold - 1;
        end
        else if (queued_cmds.size() != 0)
        begin
            c = queued_cmds.pop_front();
            command   <= c.op;
            value     <= c.data;
            position  <= c.pos;
            in_valid  <= 1'b1;
            send_hold <= c.hurry ? 0 : $urandom_range(0, 14);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: draws a stall after every transaction; every third window
    // of 48 replies runs without stalls. Once, after 50 replies, it holds
    // off ready so the result queue fills and the input backs up.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        int gap;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (ready_hold != 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (res_taken)
        begin
            if (!long_hold_done && replies_seen >= 50)
            begin
                long_hold_done <= 1'b1;
                out_ready      <= 1'b0;
                ready_hold     <= 299;
            end
            else
            begin
                gap = ((replies_seen / 48) % 3 == 2) ? 0 : $urandom_range(0, 14);
                if (gap == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready  <= 1'b0;
                    ready_hold <= gap - 1;
                end
            end
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge. An accepted
    // command updates the model; a reply is checked against the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        result_t exp;
        cmd_taken <= rst_n && in_valid && in_ready;
        res_taken <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            update_list_model(cmd_t'(command), value, position);
        end
        if (rst_n && out_valid && out_ready)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("reply with nothing predicted: read_value %0d entry_count %0d status %0d",
                       read_value, entry_count, status);
                mismatches++;
            end
            else
            begin
                exp = pending_replies.pop_front();
                if (read_value !== exp.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", exp.read_value, read_value);
                    mismatches++;
                end
                if (entry_count !== exp.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", exp.entry_count, entry_count);
                    mismatches++;
                end
                if (status !== exp.status)
                begin
                    $error("status: expected %0d, got %0d", exp.status, status);
                    mismatches++;
                end
                if (last !== exp.last)
                begin
                    $error("last: expected %0d, got %0d", exp.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int phase;
        int wait_cycles;

        // directed: empty-list cases, position edges, value extremes
        queue_cmd(CMD_DEL_FRONT, 0, 0, 1'b0);
        queue_cmd(CMD_DEL_BACK, 0, 0, 1'b0);
        queue_cmd(CMD_DEL_AT, 0, 3, 1'b0);          // empty, position ignored
        queue_cmd(CMD_READ_ALL, 0, 0, 1'b0);
        queue_cmd(CMD_COUNT, 0, 0, 1'b0);
        queue_cmd(CMD_INS_AT, 5, 0, 1'b0);          // position zero
        queue_cmd(CMD_INS_AT, 6, 2, 1'b0);          // past count+1
        queue_cmd(CMD_INS_AT, 32'sh7fff_ffff, 1, 1'b0);
        queue_cmd(CMD_INS_FRONT, 32'sh8000_0000, 0, 1'b1);
        queue_cmd(CMD_INS_BACK, -1, 0, 1'b1);
        queue_cmd(CMD_INS_AT, 0, 2, 1'b0);          // middle
        queue_cmd(CMD_INS_AT, 32'sh5555_5555, 5, 1'b0); // append via count+1
        queue_cmd(CMD_INS_AT, 32'shaaaa_aaaa, 255, 1'b0);
        queue_cmd(CMD_READ_ALL, 0, 0, 1'b0);
        queue_cmd(CMD_DEL_AT, 0, 0, 1'b0);
        queue_cmd(CMD_DEL_AT, 0, 6, 1'b0);          // count+1
        queue_cmd(CMD_DEL_AT, 0, 255, 1'b0);
        queue_cmd(CMD_DEL_AT, 0, 3, 1'b1);          // middle
        queue_cmd(CMD_DEL_AT, 0, 4, 1'b0);          // back by position
        queue_cmd(CMD_DEL_FRONT, 0, 0, 1'b0);
        queue_cmd(CMD_DEL_BACK, 0, 0, 1'b0);
        queue_cmd(CMD_COUNT, 0, 0, 1'b0);
        queue_cmd(CMD_READ_ALL, 0, 0, 1'b0);

        // fill to capacity with random inserts, then hit the full cases
        while (gen_count < CAPACITY)
        begin
            queue_cmd(cmd_t'($urandom_range(0, 2)), pick_value(),
                      $urandom_range(1, gen_count + 1), $urandom_range(0, 1));
        end
        queue_cmd(CMD_INS_FRONT, $urandom, 0, 1'b0);
        queue_cmd(CMD_INS_BACK, $urandom, 0, 1'b0);
        queue_cmd(CMD_INS_AT, $urandom, 1, 1'b0);
        queue_cmd(CMD_INS_AT, $urandom, 200, 1'b0); // full beats bad position
        queue_cmd(CMD_READ_ALL, 0, 0, 1'b0);
        queue_cmd(CMD_COUNT, 0, 0, 1'b0);

        // random phases: shrink, balanced, grow; some without sender gaps
        phase = 0;
        while (queued_total < 280)
        begin
            for (int i = 0; i < 30; i++)
            begin
                queue_random_cmd((phase % 3 == 0) ? 30 : (phase % 3 == 1) ? 50 : 70,
                                 (phase % 4 == 2));
            end
            phase++;
        end

        // drain to empty, then the empty cases once more
        while (gen_count > 0)
        begin
            queue_cmd(cmd_t'($urandom_range(3, 5)), $urandom,
                      $urandom_range(1, gen_count), 1'b0);
        end
        queue_cmd(CMD_DEL_AT, 0, $urandom_range(0, 255), 1'b0);
        queue_cmd(CMD_READ_ALL, 0, 0, 1'b0);
        queue_cmd(CMD_COUNT, 0, 0, 1'b0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_cmds.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        wait_cycles = 0;
        while (pending_replies.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_replies.size() != 0)
        begin
            $error("%0d predicted replies never arrived", pending_replies.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### positional_list_store_core.f
rtl/pls_pkg.sv
rtl/pls_ram.sv
rtl/pls_outq.sv
rtl/pls_ctrl.sv
rtl/positional_list_store_core.sv
test/positional_list_store_core_tb.sv
